@@ rtl/oid_pkg.sv @@
// Shared types and constants for the obstacle inflation block.
package oid_pkg;
	localparam int unsigned MaxWidthDef = 256;
	localparam int unsigned MaxHeightDef = 256;
	localparam int unsigned MaxHalfDef = 15;
	localparam int unsigned MaxStep = 16;
	localparam logic [7:0] FullWhite = 8'd255;

	localparam int unsigned CfgAddrW = 3;
	localparam logic [CfgAddrW-1:0] RegWidth = 3'd0;
	localparam logic [CfgAddrW-1:0] RegHeight = 3'd1;
	localparam logic [CfgAddrW-1:0] RegHalfRows = 3'd2;
	localparam logic [CfgAddrW-1:0] RegHalfCols = 3'd3;
	localparam logic [CfgAddrW-1:0] RegStep = 3'd4;

	localparam logic OpPixel = 1'b0;
	localparam logic OpDrain = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} in_item_t;

	typedef struct packed {
		logic [7:0] pixel_row;
		logic [7:0] pixel_col;
		logic       is_occupied;
		logic       on_grid;
		logic [7:0] grid_row;
		logic [7:0] grid_col;
		logic       frame_last;
	} out_item_t;

	typedef struct packed {
		logic [CfgAddrW-1:0] index;
		logic [15:0]         data;
	} cfg_item_t;
endpackage

@@ rtl/oid_stream_if.sv @@
// Valid/ready channel interfaces for input items, result items and configuration writes.
interface oid_in_if;
	logic valid;
	logic ready;
	oid_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface oid_out_if;
	logic valid;
	logic ready;
	oid_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface oid_cfg_if;
	logic valid;
	logic ready;
	oid_pkg::cfg_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/oid_bit_store.sv @@
// One-bit-wide synchronous obstacle flag memory with one write and one registered read port.
module oid_bit_store #(
	parameter int unsigned Depth = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic                     wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic                     rdata
);
	logic mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/oid_grid_div.sv @@
// Sequential restoring divider giving a coordinate's quotient by the grid step and whether the remainder is zero.
module oid_grid_div #(
	parameter int unsigned CoordW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CoordW-1:0] dividend,
	input  logic [4:0]        divisor,
	output logic              done,
	output logic [CoordW-1:0] quotient,
	output logic              rem_zero
);
	localparam int unsigned CntW = $clog2(CoordW + 1);
	logic [CoordW-1:0] quo_q;
	logic [5:0]        rem_q;
	logic [CntW-1:0]   cnt_q;
	logic              busy_q;
	logic [5:0]        trial;

	assign trial = {rem_q[4:0], quo_q[CoordW-1]};
	assign quotient = quo_q;
	assign rem_zero = (rem_q == 6'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(CoordW);
				quo_q <= dividend;
				rem_q <= '0;
			end else if (busy_q) begin
				if (trial >= {1'b0, divisor}) begin
					rem_q <= trial - {1'b0, divisor};
					quo_q <= {quo_q[CoordW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[CoordW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

@@ rtl/obstacle_inflation_dilation_unit.sv @@
// Obstacle inflation: raster pixels in, dilated occupancy and grid info out.
//
// Channels: in_ch carries pixel or drain items, out_ch carries result items,
// cfg_ch writes the five geometry registers by index; the user must write
// them only while the block is idle, which the block does not enforce. Each
// pixel item, while the frame is not yet complete, writes its obstacle flag
// into a one-bit frame store. When the window of the next pending result has
// fully arrived, the block sweeps that window through the store, one entry
// per cycle on the single read port, while two shift-and-subtract dividers
// derive grid coordinates in parallel. An item that causes no result returns
// the block to idle after the check; one that does waits for the sweep of a
// non-empty window over the store read port and for the eight-step dividers.
// A result waits in an output register; while the receiver stalls it the
// block takes no new item. Reset clears all positions and the frame flag and
// loads the register defaults; the store holds no reset value and each entry
// is written before it is read.
module obstacle_inflation_dilation_unit #(
	parameter int unsigned MAX_WIDTH = oid_pkg::MaxWidthDef,
	parameter int unsigned MAX_HEIGHT = oid_pkg::MaxHeightDef,
	parameter int unsigned MAX_HALF_WINDOW = oid_pkg::MaxHalfDef
) (
	input logic clk,
	input logic arst_n,
	oid_in_if.sink in_ch,
	oid_out_if.source out_ch,
	oid_cfg_if.sink cfg_ch
);
	localparam int unsigned RowW = $clog2(MAX_HEIGHT + 1) + 1;
	localparam int unsigned ColW = $clog2(MAX_WIDTH + 1) + 1;
	localparam int unsigned RaW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned CaW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned AddrW = RaW + CaW;
	localparam int unsigned HalfW = $clog2(MAX_HALF_WINDOW + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_CHECK, ST_SCAN, ST_WAIT, ST_OUT
	} state_t;
	state_t state_q;

	logic [8:0] width_q, height_q;
	logic [3:0] hr_cfg_q, hc_cfg_q;
	logic [4:0] step_cfg_q;

	logic [RowW-1:0] in_row_q, out_row_q, w_row_q, win_rhi_q;
	logic [ColW-1:0] in_col_q, out_col_q, w_col_q, win_clo_q, win_chi_q;
	logic            frame_q, occ_q, rd_pend_q, div_done_q;

	logic [RowW-1:0] h_eff_r;
	logic [ColW-1:0] w_eff_c;
	logic [HalfW-1:0] hr, hc;
	logic [4:0] step;

	always_comb begin
		w_eff_c = (width_q == 9'd0) ? ColW'(1)
			: (ColW'(width_q) > ColW'(MAX_WIDTH)) ? ColW'(MAX_WIDTH) : ColW'(width_q);
		h_eff_r = (height_q == 9'd0) ? RowW'(1)
			: (RowW'(height_q) > RowW'(MAX_HEIGHT)) ? RowW'(MAX_HEIGHT) : RowW'(height_q);
		hr = (32'(hr_cfg_q) > MAX_HALF_WINDOW) ? HalfW'(MAX_HALF_WINDOW) : HalfW'(hr_cfg_q);
		hc = (32'(hc_cfg_q) > MAX_HALF_WINDOW) ? HalfW'(MAX_HALF_WINDOW) : HalfW'(hc_cfg_q);
		step = (step_cfg_q == 5'd0) ? 5'd1 : (step_cfg_q > 5'd16) ? 5'd16 : step_cfg_q;
	end

	// Configuration.
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256;
			height_q <= 9'd256;
			hr_cfg_q <= 4'd0;
			hc_cfg_q <= 4'd0;
			step_cfg_q <= 5'd1;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.data.index)
				oid_pkg::RegWidth: width_q <= cfg_ch.data.data[8:0];
				oid_pkg::RegHeight: height_q <= cfg_ch.data.data[8:0];
				oid_pkg::RegHalfRows: hr_cfg_q <= cfg_ch.data.data[3:0];
				oid_pkg::RegHalfCols: hc_cfg_q <= cfg_ch.data.data[3:0];
				oid_pkg::RegStep: step_cfg_q <= cfg_ch.data.data[4:0];
				default: ;
			endcase
		end
	end

	// Window of the pending result (combinational from output position).
	logic [RowW-1:0] rlo, rhi, lr;
	logic [ColW-1:0] clo, chi, lc;
	logic ready_res;
	always_comb begin
		rlo = (out_row_q > RowW'(hr)) ? out_row_q - RowW'(hr) : '0;
		rhi = (out_row_q + RowW'(hr) < h_eff_r) ? out_row_q + RowW'(hr) : h_eff_r;
		clo = (out_col_q > ColW'(hc)) ? out_col_q - ColW'(hc) : '0;
		chi = (out_col_q + ColW'(hc) < w_eff_c) ? out_col_q + ColW'(hc) : w_eff_c;
		lr = out_row_q;
		lc = out_col_q;
		if (rhi > rlo && chi > clo) begin
			if ((rhi - 1'b1) > lr || ((rhi - 1'b1) == lr && (chi - 1'b1) > lc)) begin
				lr = rhi - 1'b1;
				lc = chi - 1'b1;
			end
		end
		ready_res = frame_q || lr < in_row_q || (lr == in_row_q && lc < in_col_q);
	end

	// Store.
	logic             st_we, st_rdata;
	logic [AddrW-1:0] st_waddr, st_raddr;
	logic             obst;
	assign obst = (in_ch.data.red != oid_pkg::FullWhite) ||
		(in_ch.data.green != oid_pkg::FullWhite) || (in_ch.data.blue != oid_pkg::FullWhite);
	assign st_we = (state_q == ST_IDLE) && in_ch.valid &&
		(in_ch.data.operation == oid_pkg::OpPixel) && !frame_q &&
		(in_row_q < RowW'(MAX_HEIGHT)) && (in_col_q < ColW'(MAX_WIDTH));
	assign st_waddr = {in_row_q[RaW-1:0], in_col_q[CaW-1:0]};
	assign st_raddr = {w_row_q[RaW-1:0], w_col_q[CaW-1:0]};

	oid_bit_store #(.Depth(1 << AddrW)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(obst),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	// Grid dividers.
	logic div_start, dr_done, dc_done, dr_zero, dc_zero;
	logic [7:0] dr_q, dc_q;
	assign div_start = (state_q == ST_CHECK) && ready_res;
	oid_grid_div #(.CoordW(8)) u_div_row (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(out_row_q[7:0]),
		.divisor(step), .done(dr_done), .quotient(dr_q), .rem_zero(dr_zero)
	);
	oid_grid_div #(.CoordW(8)) u_div_col (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(out_col_q[7:0]),
		.divisor(step), .done(dc_done), .quotient(dc_q), .rem_zero(dc_zero)
	);

	logic last;
	assign last = (out_row_q + 1'b1 >= h_eff_r) && (out_col_q + 1'b1 >= w_eff_c);
	assign in_ch.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			in_row_q <= '0;
			in_col_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			frame_q <= 1'b0;
			out_ch.valid <= 1'b0;
			occ_q <= 1'b0;
			rd_pend_q <= 1'b0;
			div_done_q <= 1'b0;
			w_row_q <= '0;
			w_col_q <= '0;
			win_rhi_q <= '0;
			win_clo_q <= '0;
			win_chi_q <= '0;
			out_ch.data <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						if (in_ch.data.operation == oid_pkg::OpPixel && !frame_q) begin
							if (in_col_q + 1'b1 >= w_eff_c) begin
								in_col_q <= '0;
								if (in_row_q + 1'b1 >= h_eff_r) begin
									in_row_q <= '0;
									frame_q <= 1'b1;
								end else begin
									in_row_q <= in_row_q + 1'b1;
								end
							end else begin
								in_col_q <= in_col_q + 1'b1;
							end
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (ready_res) begin
						win_rhi_q <= rhi;
						win_clo_q <= clo;
						win_chi_q <= chi;
						w_row_q <= rlo;
						w_col_q <= clo;
						occ_q <= 1'b0;
						rd_pend_q <= 1'b0;
						div_done_q <= 1'b0;
						if (rhi > rlo && chi > clo) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_WAIT;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (dr_done) div_done_q <= 1'b1;
					if (rd_pend_q && st_rdata) occ_q <= 1'b1;
					rd_pend_q <= 1'b1;
					if (w_col_q + 1'b1 >= win_chi_q) begin
						w_col_q <= win_clo_q;
						if (w_row_q + 1'b1 >= win_rhi_q) begin
							state_q <= ST_WAIT;
						end else begin
							w_row_q <= w_row_q + 1'b1;
						end
					end else begin
						w_col_q <= w_col_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (rd_pend_q && st_rdata) occ_q <= 1'b1;
					rd_pend_q <= 1'b0;
					if (dr_done && dc_done) div_done_q <= 1'b1;
					if (div_done_q || (dr_done && dc_done)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_ch.valid) begin
						out_ch.valid <= 1'b1;
						out_ch.data.pixel_row <= out_row_q[7:0];
						out_ch.data.pixel_col <= out_col_q[7:0];
						out_ch.data.is_occupied <= occ_q;
						out_ch.data.on_grid <= dr_zero && dc_zero;
						out_ch.data.grid_row <= dr_q;
						out_ch.data.grid_col <= dc_q;
						out_ch.data.frame_last <= last;
						if (last) begin
							out_row_q <= '0;
							out_col_q <= '0;
							in_row_q <= '0;
							in_col_q <= '0;
							frame_q <= 1'b0;
						end else if (out_col_q + 1'b1 >= w_eff_c) begin
							out_col_q <= '0;
							out_row_q <= (out_row_q + 1'b1 >= h_eff_r) ? '0 : out_row_q + 1'b1;
						end else begin
							out_col_q <= out_col_q + 1'b1;
						end
					end else if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/oid_checker.sv @@
// Port-level assertions for the obstacle inflation block, bound to the top level.
module oid_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_frame_last,
	input logic [7:0] out_pixel_col
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid) else $error("result repeated");
	a_col_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_pixel_col) && $stable(out_frame_last))
		else $error("result changed while stalled");
endmodule

bind obstacle_inflation_dilation_unit oid_checker u_oid_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_frame_last(out_ch.data.frame_last), .out_pixel_col(out_ch.data.pixel_col)
);

@@ verif/tb_obstacle_inflation_dilation_unit.sv @@
// Testbench for the obstacle inflation unit: frames in, predicted dilation results checked.
`timescale 1ns / 100ps

module tb_obstacle_inflation_dilation_unit;
	localparam int unsigned StallLimit = 20000;
	localparam int unsigned SettleCycles = 24;
	localparam int unsigned ItemTarget = 1500;

	logic clk;
	logic arst_n;

	oid_in_if in_bus();
	oid_out_if out_bus();
	oid_cfg_if cfg_bus();

	obstacle_inflation_dilation_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_bus),
		.out_ch(out_bus),
		.cfg_ch(cfg_bus)
	);

	// Shadow of the block's state and registers.
	bit obstacle_map[oid_pkg::MaxWidthDef * oid_pkg::MaxHeightDef];
	int unsigned in_row, in_col, res_row, res_col;
	bit frame_in;
	int unsigned width_reg, height_reg, half_rows_reg, half_cols_reg, step_reg;

	oid_pkg::out_item_t pending_results[$];
	int unsigned mismatches;
	int unsigned items_sent;
	int unsigned hold_request;
	bit calm;
	int unsigned quiet_cycles;

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int unsigned frame_width();
		return clamp(width_reg, 1, oid_pkg::MaxWidthDef);
	endfunction

	function automatic int unsigned frame_height();
		return clamp(height_reg, 1, oid_pkg::MaxHeightDef);
	endfunction

	function automatic void apply_register(logic [oid_pkg::CfgAddrW-1:0] idx,
			logic [15:0] value);
		unique case (idx)
			oid_pkg::RegWidth: begin
				width_reg = 32'(value[8:0]);
			end
			oid_pkg::RegHeight: begin
				height_reg = 32'(value[8:0]);
			end
			oid_pkg::RegHalfRows: begin
				half_rows_reg = 32'(value[3:0]);
			end
			oid_pkg::RegHalfCols: begin
				half_cols_reg = 32'(value[3:0]);
			end
			oid_pkg::RegStep: begin
				step_reg = 32'(value[4:0]);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void predict_dilation(oid_pkg::in_item_t it);
		int unsigned w, h, hr, hc, step, r, c;
		int unsigned rlo, rhi, clo, chi, lr, lc;
		bit ready_now, occ, last;
		oid_pkg::out_item_t res;
		w = frame_width();
		h = frame_height();
		hr = clamp(half_rows_reg, 0, oid_pkg::MaxHalfDef);
		hc = clamp(half_cols_reg, 0, oid_pkg::MaxHalfDef);
		step = clamp(step_reg, 1, oid_pkg::MaxStep);
		r = res_row;
		c = res_col;
		occ = 1'b0;
		if (it.operation == oid_pkg::OpPixel && !frame_in) begin
			obstacle_map[in_row * oid_pkg::MaxWidthDef + in_col] =
				it.red != oid_pkg::FullWhite || it.green != oid_pkg::FullWhite ||
				it.blue != oid_pkg::FullWhite;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
				if (in_row >= h) begin
					in_row = 0;
					frame_in = 1'b1;
				end
			end
		end
		rlo = (r > hr) ? r - hr : 0;
		rhi = (r + hr < h) ? r + hr : h;
		clo = (c > hc) ? c - hc : 0;
		chi = (c + hc < w) ? c + hc : w;
		lr = r;
		lc = c;
		if (rhi > rlo && chi > clo) begin
			if (rhi - 1 > lr || (rhi - 1 == lr && chi - 1 > lc)) begin
				lr = rhi - 1;
				lc = chi - 1;
			end
		end
		ready_now = frame_in || lr < in_row || (lr == in_row && lc < in_col);
		if (!ready_now)
			return;
		for (int unsigned i = rlo; i < rhi; i++)
			for (int unsigned j = clo; j < chi; j++)
				if (obstacle_map[i * oid_pkg::MaxWidthDef + j])
					occ = 1'b1;
		last = (r + 1 >= h) && (c + 1 >= w);
		res.pixel_row = r[7:0];
		res.pixel_col = c[7:0];
		res.is_occupied = occ;
		res.on_grid = (r % step == 0) && (c % step == 0);
		res.grid_row = 8'(r / step);
		res.grid_col = 8'(c / step);
		res.frame_last = last;
		pending_results.push_back(res);
		res_col++;
		if (res_col >= w) begin
			res_col = 0;
			res_row++;
			if (res_row >= h)
				res_row = 0;
		end
		if (last) begin
			res_row = 0;
			res_col = 0;
			in_row = 0;
			in_col = 0;
			frame_in = 1'b0;
		end
	endfunction

	task automatic send_item(oid_pkg::in_item_t it);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.data <= it;
		do
			@(posedge clk);
		while (!in_bus.ready);
		predict_dilation(it);
		items_sent++;
	endtask

	task automatic wait_idle();
		in_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic program_geometry(logic [15:0] w, logic [15:0] h, logic [15:0] hr,
			logic [15:0] hc, logic [15:0] step);
		logic [oid_pkg::CfgAddrW-1:0] idx_list[5];
		logic [15:0] val_list[5];
		idx_list = '{oid_pkg::RegWidth, oid_pkg::RegHeight, oid_pkg::RegHalfRows,
			oid_pkg::RegHalfCols, oid_pkg::RegStep};
		val_list = '{w, h, hr, hc, step};
		wait_idle();
		for (int k = 0; k < 5; k++) begin
			cfg_bus.valid <= 1'b1;
			cfg_bus.data <= '{index: idx_list[k], data: val_list[k]};
			do
				@(posedge clk);
			while (!cfg_bus.ready);
			apply_register(idx_list[k], val_list[k]);
		end
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic oid_pkg::in_item_t make_pixel(int unsigned obstacle_pct);
		oid_pkg::in_item_t it;
		it.operation = oid_pkg::OpPixel;
		it.red = oid_pkg::FullWhite;
		it.green = oid_pkg::FullWhite;
		it.blue = oid_pkg::FullWhite;
		if ($urandom_range(0, 99) < obstacle_pct) begin
			case ($urandom_range(0, 3))
				0: it.red = 8'($urandom_range(0, 254));
				1: it.green = 8'($urandom_range(0, 254));
				2: it.blue = 8'($urandom_range(0, 254));
				default: begin
					it.red = 8'($urandom);
					it.green = 8'($urandom);
					it.blue = 8'($urandom);
				end
			endcase
		end
		return it;
	endfunction

	function automatic oid_pkg::in_item_t make_drain();
		oid_pkg::in_item_t it;
		it.operation = oid_pkg::OpDrain;
		it.red = 8'($urandom);
		it.green = 8'($urandom);
		it.blue = 8'($urandom);
		return it;
	endfunction

	task automatic run_frame(int unsigned obstacle_pct, bit noisy);
		int unsigned pixels;
		pixels = frame_width() * frame_height();
		for (int unsigned p = 0; p < pixels; p++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_item(make_drain());
			send_item(make_pixel(obstacle_pct));
		end
		while (frame_in) begin
			if (noisy && $urandom_range(0, 3) == 0)
				send_item(make_pixel(50));
			else
				send_item(make_drain());
		end
	endtask

	task automatic test_single_pixel_frames();
		oid_pkg::in_item_t it;
		program_geometry(16'd0, 16'd0, 16'd15, 16'd15, 16'd0);
		for (int k = 0; k < 6; k++) begin
			it = '{operation: oid_pkg::OpPixel, red: oid_pkg::FullWhite,
				green: oid_pkg::FullWhite, blue: oid_pkg::FullWhite};
			case (k)
				1: it.red = 8'd254;
				2: it.green = 8'd0;
				3: it.blue = 8'd127;
				4: it = '{operation: oid_pkg::OpPixel, red: 8'd0, green: 8'd0, blue: 8'd0};
				default: begin
				end
			endcase
			send_item(make_drain());
			send_item(it);
			while (frame_in)
				send_item(make_drain());
		end
	endtask

	task automatic test_widest_row();
		program_geometry(16'd511, 16'd1, 16'd1, 16'd15, 16'd31);
		run_frame(3, 1'b0);
	endtask

	task automatic test_tallest_column();
		program_geometry(16'd1, 16'd256, 16'd15, 16'd1, 16'd17);
		run_frame(3, 1'b0);
	endtask

	task automatic test_empty_window();
		program_geometry(16'd7, 16'd5, 16'd0, 16'd3, 16'd2);
		run_frame(30, 1'b1);
		program_geometry(16'd5, 16'd4, 16'd2, 16'd0, 16'd3);
		run_frame(30, 1'b1);
	endtask

	task automatic test_backpressure();
		program_geometry(16'd8, 16'd8, 16'd1, 16'd1, 16'd1);
		calm = 1'b1;
		hold_request = 400;
		run_frame(20, 1'b0);
		calm = 1'b0;
	endtask

	task automatic test_random_frames();
		int unsigned w, h, hr, hc, step;
		while (items_sent < ItemTarget) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
			h = $urandom_range(1, 12);
			hr = $urandom_range(0, 4);
			hc = $urandom_range(0, 4);
			if ($urandom_range(0, 19) == 0) begin
				w = $urandom_range(1, 4);
				h = $urandom_range(1, 4);
				hr = 15;
				hc = $urandom_range(0, 15);
			end
			step = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
			if ($urandom_range(0, 15) == 0)
				w = 0;
			program_geometry(16'(w), 16'(h), 16'(hr), 16'(hc), 16'(step));
			calm = ($urandom_range(0, 4) == 0);
			run_frame($urandom_range(0, 40), $urandom_range(0, 2) != 0);
			calm = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_bus.valid = 1'b0;
		in_bus.data = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = '0;
		mismatches = 0;
		items_sent = 0;
		hold_request = 0;
		calm = 1'b0;
		in_row = 0;
		in_col = 0;
		res_row = 0;
		res_col = 0;
		frame_in = 1'b0;
		width_reg = oid_pkg::MaxWidthDef;
		height_reg = oid_pkg::MaxHeightDef;
		half_rows_reg = 0;
		half_cols_reg = 0;
		step_reg = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_pixel_frames();
		test_empty_window();
		test_widest_row();
		test_tallest_column();
		test_backpressure();
		test_random_frames();
		wait_idle();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int unsigned stall;
		oid_pkg::out_item_t got, exp_res;
		out_bus.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 14);
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end
			if (stall > 0) begin
				out_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_bus.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(out_bus.valid && out_bus.ready));
			got = out_bus.data;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result item: row %0d col %0d", got.pixel_row,
						got.pixel_col);
			end else begin
				exp_res = pending_results.pop_front();
				if (got.pixel_row !== exp_res.pixel_row || got.pixel_col !== exp_res.pixel_col ||
						got.is_occupied !== exp_res.is_occupied ||
						got.on_grid !== exp_res.on_grid || got.grid_row !== exp_res.grid_row ||
						got.grid_col !== exp_res.grid_col ||
						got.frame_last !== exp_res.frame_last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %p, got %p", exp_res, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("Timeout: no item accepted for %0d cycles", StallLimit);
				$display("*** FAILED ***");
				$finish;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end
endmodule
